// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for the concurrent checks of the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// When ante holds, cons must hold at the following clock edge.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/skt_pkg.sv =====
// ----------------------------------------------------------------------------
// skt_pkg
// Types and constants shared by the sorted key table modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package skt_pkg;

   localparam int KEY_W        = 16;
   localparam int HANDLE_W     = 32;
   localparam int ACTION_W     = 2;
   localparam int STATUS_W     = 2;
   localparam int COUNT_W      = 7;
   localparam int DEF_CAPACITY = 64;

   localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_MISSING = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [KEY_W-1:0]    key;
      logic [HANDLE_W-1:0] handle;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [HANDLE_W-1:0] found_handle;
      logic [COUNT_W-1:0]  entry_count;
   } rsp_type;

   typedef struct packed {
      logic [KEY_W-1:0]    key;
      logic [HANDLE_W-1:0] handle;
   } entry_type;

endpackage

// ===== sv/skt_ram.sv =====
// ----------------------------------------------------------------------------
// skt_ram
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module skt_ram
   import skt_pkg::*;
#(
   parameter int DEPTH = DEF_CAPACITY,
   parameter int AW    = $clog2(DEF_CAPACITY)
) (
   input  logic            clock,
   input  logic            wr_en,
   input  logic [AW-1:0]   wr_addr,
   input  entry_type       wr_data,
   input  logic [AW-1:0]   rd_addr,
   output entry_type       rd_data
);

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/sorted_key_table.sv =====
// ----------------------------------------------------------------------------
// sorted_key_table
// Table of key/handle entries kept in ascending key order in one memory.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Ports                               Content
//   req      in         req_valid, req_ready, req_data      action, key, handle
//   rsp      out        rsp_valid, rsp_ready, rsp_data      status, handle, count
//
// One transaction is handled at a time. A lookup scans up from the lowest
// key, reading one entry per cycle from the single read port. An insert or
// remove then shifts the later entries by one place. The scan and the shift
// together cover the held entries once. A full-table insert or an unknown
// action skips the scan and goes straight to the response state. Reset
// clears the entry count and control only; the memory needs no clearing
// because only entries below the count are read. A new request is taken
// while a finished response still waits on rsp_ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_key_table
   import skt_pkg::*;
#(
   parameter int CAPACITY = DEF_CAPACITY
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

`include "assert_macros.svh"

   localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CW    = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
   localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

   // Sequencer states, one-hot.
   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_SCAN  = 5'b00010,
      S_SHIFT = 5'b00100,
      S_WRITE = 5'b01000,
      S_RESP  = 5'b10000
   } state_type;

   state_type           state_ff, state_in;
   req_type             req_ff, req_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   // Scan position: address of the entry in the read register while dv_ff is
   // set, and the insert or remove position once the scan ends.
   logic [CNT_W-1:0]    pos_ff, pos_in;
   logic                dv_ff, dv_in;
   // Shift source counter, and the pending write of a moved entry.
   logic [CNT_W-1:0]    src_ff, src_in;
   logic                sdv_ff, sdv_in;
   logic [AW-1:0]       dst_ff, dst_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [HANDLE_W-1:0] res_handle_ff, res_handle_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic                mem_we;
   logic [AW-1:0]       mem_wr_addr;
   entry_type           mem_wr_data;
   logic [AW-1:0]       mem_rd_addr;
   entry_type           mem_rd_data;

   logic [CNT_W-1:0]    pos_inc;
   logic [CNT_W-1:0]    src_inc;
   logic [CNT_W-1:0]    src_dec;
   logic [CNT_W-1:0]    count_inc;
   logic [CNT_W-1:0]    count_dec;
   logic [CW-1:0]       count_ext;
   logic                scan_end;
   logic                scan_hit;
   logic                shift_more;
   logic                is_insert;

   skt_ram #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign pos_inc   = pos_ff + 1'b1;
   assign src_inc   = src_ff + 1'b1;
   assign src_dec   = src_ff - 1'b1;
   assign count_inc = count_ff + 1'b1;
   assign count_dec = count_ff - 1'b1;
   assign count_ext = CW'(count_ff);
   assign is_insert = (req_ff.action == ACT_INSERT);

   // The scan stops at the first entry whose key is not below the request
   // key, or when every held entry has been examined.
   always_comb begin
      scan_end = 1'b0;
      scan_hit = 1'b0;
      if (dv_ff) begin
         if (!(mem_rd_data.key < req_ff.key)) begin
            scan_end = 1'b1;
            scan_hit = (mem_rd_data.key == req_ff.key);
         end else if (pos_inc == count_ff) begin
            scan_end = 1'b1;
         end
      end else if (pos_ff == count_ff) begin
         scan_end = 1'b1;
      end
   end

   // Insert moves entries up from the top down to the position; remove
   // moves entries down from just above the position to the top.
   assign shift_more = is_insert ? (src_ff > pos_ff) : (src_ff < count_ff);

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      dv_in         = dv_ff;
      src_in        = src_ff;
      sdv_in        = sdv_ff;
      dst_in        = dst_ff;
      res_status_in = res_status_ff;
      res_handle_in = res_handle_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      mem_we        = 1'b0;
      mem_wr_addr   = dst_ff;
      mem_wr_data   = mem_rd_data;
      mem_rd_addr   = '0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in        = req_data;
               pos_in        = '0;
               dv_in         = 1'b0;
               sdv_in        = 1'b0;
               res_status_in = ST_MISSING;
               res_handle_in = '0;
               case (req_data.action)
                  ACT_LOOKUP, ACT_REMOVE: begin
                     state_in = S_SCAN;
                  end
                  ACT_INSERT: begin
                     if (count_ff == CAP_C) begin
                        res_status_in = ST_FULL;
                        state_in      = S_RESP;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end

         S_SCAN: begin
            if (scan_end) begin
               dv_in = 1'b0;
               // Every held entry was below the key: the position is the end.
               if (dv_ff && (mem_rd_data.key < req_ff.key)) begin
                  pos_in = pos_inc;
               end
               case (req_ff.action)
                  ACT_INSERT: begin
                     src_in   = count_ff;
                     state_in = S_SHIFT;
                  end
                  ACT_REMOVE: begin
                     if (scan_hit) begin
                        src_in   = pos_inc;
                        state_in = S_SHIFT;
                     end else begin
                        state_in = S_RESP;
                     end
                  end
                  default: begin
                     if (scan_hit) begin
                        res_status_in = ST_OK;
                        res_handle_in = mem_rd_data.handle;
                     end
                     state_in = S_RESP;
                  end
               endcase
            end else if (dv_ff) begin
               pos_in      = pos_inc;
               dv_in       = 1'b1;
               mem_rd_addr = pos_inc[AW-1:0];
            end else begin
               dv_in       = 1'b1;
               mem_rd_addr = pos_ff[AW-1:0];
            end
         end

         S_SHIFT: begin
            if (sdv_ff) begin
               mem_we      = 1'b1;
               mem_wr_addr = dst_ff;
               mem_wr_data = mem_rd_data;
            end
            if (shift_more) begin
               sdv_in = 1'b1;
               if (is_insert) begin
                  mem_rd_addr = src_dec[AW-1:0];
                  dst_in      = src_ff[AW-1:0];
                  src_in      = src_dec;
               end else begin
                  mem_rd_addr = src_ff[AW-1:0];
                  dst_in      = src_dec[AW-1:0];
                  src_in      = src_inc;
               end
            end else begin
               sdv_in = 1'b0;
               if (!sdv_ff) begin
                  if (is_insert) begin
                     state_in = S_WRITE;
                  end else begin
                     count_in      = count_dec;
                     res_status_in = ST_OK;
                     state_in      = S_RESP;
                  end
               end
            end
         end

         S_WRITE: begin
            mem_we             = 1'b1;
            mem_wr_addr        = pos_ff[AW-1:0];
            mem_wr_data.key    = req_ff.key;
            mem_wr_data.handle = req_ff.handle;
            count_in           = count_inc;
            res_status_in      = ST_OK;
            state_in           = S_RESP;
         end

         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.status       = res_status_ff;
               rsp_in.found_handle = res_handle_ff;
               rsp_in.entry_count  = count_ext[COUNT_W-1:0];
               rsp_valid_in        = 1'b1;
               state_in            = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         dv_ff        <= 1'b0;
         sdv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dv_ff        <= dv_in;
         sdv_ff       <= sdv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      pos_ff        <= pos_in;
      src_ff        <= src_in;
      dst_ff        <= dst_in;
      res_status_ff <= res_status_in;
      res_handle_ff <= res_handle_in;
      rsp_ff        <= rsp_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // The entry count never exceeds the table size.
   `ASSERT_ALWAYS(a_count_range, clock, reset, count_ff <= CAP_C, "entry count above capacity")

   // Every memory write lands at or below the current count.
   `ASSERT_ALWAYS(a_write_range, clock, reset, !mem_we || (CNT_W'(mem_wr_addr) <= count_ff), "entry write beyond the held entries")

   // Accepting a request leaves the count alone for that cycle.
   `ASSERT_NEXT(a_count_hold, clock, reset, req_valid && req_ready, count_ff == $past(count_ff), "count changed on request acceptance")

   // A shift write is only pending while the sequencer is in the shift state.
   `ASSERT_ALWAYS(a_shift_state, clock, reset, !sdv_ff || (state_ff == S_SHIFT), "shift write pending outside shift")

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for sorted_key_table: a directed table of lookups,
// inserts and removes, followed by random fill, mixed and drain passes, all
// checked transaction by transaction against hand-written responses or an in-bench table predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import skt_pkg::*;

   localparam int CAPACITY     = DEF_CAPACITY;
   localparam int RANDOM_ITEMS = 1400;
   // The slowest transaction scans and shifts the whole table. The tail wait
   // after the last response covers that with margin.
   localparam int TAIL_CYCLES  = 2 * CAPACITY + 20;
   // Cycles without any accepted transaction before the run is declared hung.
   localparam int IDLE_LIMIT   = 4000;

   // Action code 3 is not assigned; the block answers it as a miss.
   localparam logic [ACTION_W-1:0] ACT_RESERVED = 2'd3;

   // Directed rows either carry a hand-written response or defer to the
   // predictor.
   localparam bit KNOWN = 1'b1;
   localparam bit CALC  = 1'b0;
   localparam rsp_type NO_RSP = '0;

   typedef struct packed {
      req_type op;
      bit      has_known;
      rsp_type known;
   } stim_row_type;

   // Random traffic runs in passes: fill the table to the top, churn it, then
   // drain it back to empty.
   typedef enum int {PH_FILL, PH_MIX, PH_DRAIN} traffic_phase_type;

   // Key distribution of one pass. A narrow span forces many equal keys.
   typedef enum int {SPAN_NARROW, SPAN_FULL, SPAN_TOP} key_span_type;

   // Receiver behavior, chosen anew at random when the current mode runs out.
   typedef enum int {RDY_ALWAYS, RDY_HALF, RDY_EVERY_FOURTH, RDY_SPARSE} ready_mode_type;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   sorted_key_table #(
      .CAPACITY(CAPACITY)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Predictor: a mirror of the sorted table. Only positions below the entry
   // count are ever read, so the stores need no reset.
   // -------------------------------------------------------------------------
   logic [KEY_W-1:0]    mirror_keys    [CAPACITY];
   logic [HANDLE_W-1:0] mirror_handles [CAPACITY];
   int                  mirror_count = 0;

   // Responses predicted for accepted requests, oldest first.
   rsp_type answer_q [$];
   int      mismatches = 0;

   // Position of the first entry whose key is not below k. An insert goes
   // here, so a new entry lands ahead of any entries with an equal key.
   function automatic int first_not_below(logic [KEY_W-1:0] k);
      int i = 0;
      while (i < mirror_count && mirror_keys[i] < k) i++;
      return i;
   endfunction

   // Applies one request to the mirror and returns the response it causes.
   function automatic rsp_type table_op_outcome(req_type op);
      rsp_type res;
      int      pos;
      bit      hit;
      res     = NO_RSP;
      res.status = ST_MISSING;
      pos     = first_not_below(op.key);
      hit     = (pos < mirror_count) && (mirror_keys[pos] == op.key);
      case (op.action)
         ACT_LOOKUP: begin
            if (hit) begin
               res.status       = ST_OK;
               res.found_handle = mirror_handles[pos];
            end
         end
         ACT_INSERT: begin
            if (mirror_count >= CAPACITY) begin
               res.status = ST_FULL;
            end else begin
               for (int i = mirror_count; i > pos; i--) begin
                  mirror_keys[i]    = mirror_keys[i-1];
                  mirror_handles[i] = mirror_handles[i-1];
               end
               mirror_keys[pos]    = op.key;
               mirror_handles[pos] = op.handle;
               mirror_count++;
               res.status = ST_OK;
            end
         end
         ACT_REMOVE: begin
            if (hit) begin
               for (int i = pos; i + 1 < mirror_count; i++) begin
                  mirror_keys[i]    = mirror_keys[i+1];
                  mirror_handles[i] = mirror_handles[i+1];
               end
               mirror_count--;
               res.status = ST_OK;
            end
         end
         default: begin
            // The reserved action leaves the table alone and reports a miss.
         end
      endcase
      res.entry_count = COUNT_W'(mirror_count);
      return res;
   endfunction

   task automatic flag_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      mismatches++;
   endtask

   // -------------------------------------------------------------------------
   // Sender. Requests go out in bursts of random length. Between bursts
   // req_valid drops for a random gap. Valid is only lowered when a gap
   // really follows, so a back-to-back request never sees valid fall and rise
   // in the same time step.
   // -------------------------------------------------------------------------
   int burst_left = 0;

   task automatic send_op(input req_type op, input bit has_known, input rsp_type known);
      rsp_type predicted;
      int      gap;
      req_valid <= 1'b1;
      req_data  <= op;
      do @(posedge clock); while (!req_ready);
      // The transaction was accepted at this edge. The mirror is updated even
      // for rows whose response is written out by hand.
      predicted = table_op_outcome(op);
      answer_q.push_back(has_known ? known : predicted);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         // One burst in five is a long stretch with no idling at all.
         if ($urandom_range(0, 4) == 0) begin
            burst_left = $urandom_range(30, 80);
            gap        = 0;
         end else begin
            burst_left = $urandom_range(0, 12);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
         end
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Picks a key from the span of the current pass.
   function automatic logic [KEY_W-1:0] random_key(key_span_type span);
      case (span)
         SPAN_NARROW: return KEY_W'($urandom_range(0, 15));
         SPAN_TOP:    return KEY_W'($urandom_range(16'hFFF0, 16'hFFFF));
         default:     return KEY_W'($urandom_range(0, 16'hFFFF));
      endcase
   endfunction

   // Lookups and removes mostly aim at a key that is present, so that hits,
   // including hits among runs of equal keys, are common.
   function automatic logic [KEY_W-1:0] target_key(key_span_type span);
      if (mirror_count > 0 && $urandom_range(0, 99) < 70) begin
         return mirror_keys[$urandom_range(0, mirror_count - 1)];
      end
      return random_key(span);
   endfunction

   // -------------------------------------------------------------------------
   // Directed table. Hand-written responses appear only where they are plain
   // to see: the empty table, the field extremes, the early inserts, misses
   // and the reserved action. Every other row is checked against the predictor.
   // -------------------------------------------------------------------------
   localparam int DIRECTED_ROWS = 25;

   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      // Empty table: lookup, remove and the reserved action all miss.
      '{'{ACT_LOOKUP,   16'h0000, 32'h0000_0000}, KNOWN, '{ST_MISSING, 32'h0, 7'd0}},
      '{'{ACT_REMOVE,   16'hFFFF, 32'hFFFF_FFFF}, KNOWN, '{ST_MISSING, 32'h0, 7'd0}},
      '{'{ACT_RESERVED, 16'h1234, 32'hFFFF_FFFF}, KNOWN, '{ST_MISSING, 32'h0, 7'd0}},
      // Extreme keys and handles, inserted out of order.
      '{'{ACT_INSERT,   16'hFFFF, 32'hFFFF_FFFF}, KNOWN, '{ST_OK, 32'h0, 7'd1}},
      '{'{ACT_INSERT,   16'h0000, 32'h0000_0000}, KNOWN, '{ST_OK, 32'h0, 7'd2}},
      '{'{ACT_LOOKUP,   16'hFFFF, 32'h0000_0000}, KNOWN, '{ST_OK, 32'hFFFF_FFFF, 7'd2}},
      // The handle field of a lookup is ignored.
      '{'{ACT_LOOKUP,   16'h0000, 32'hFFFF_FFFF}, KNOWN, '{ST_OK, 32'h0, 7'd2}},
      // Middle insert, then an equal key that must land ahead of it.
      '{'{ACT_INSERT,   16'h8000, 32'hA5A5_A5A5}, KNOWN, '{ST_OK, 32'h0, 7'd3}},
      '{'{ACT_INSERT,   16'h8000, 32'h5A5A_5A5A}, KNOWN, '{ST_OK, 32'h0, 7'd4}},
      '{'{ACT_LOOKUP,   16'h8000, 32'h0000_0000}, CALC,  NO_RSP},
      // Key missing from a populated table.
      '{'{ACT_LOOKUP,   16'h7FFF, 32'h0000_0000}, KNOWN, '{ST_MISSING, 32'h0, 7'd4}},
      '{'{ACT_REMOVE,   16'h7FFF, 32'h0000_0000}, KNOWN, '{ST_MISSING, 32'h0, 7'd4}},
      // Removing one of two equal keys takes the first; the other remains.
      '{'{ACT_REMOVE,   16'h8000, 32'h0000_0000}, CALC,  NO_RSP},
      '{'{ACT_LOOKUP,   16'h8000, 32'h0000_0000}, CALC,  NO_RSP},
      '{'{ACT_RESERVED, 16'h8000, 32'h5A5A_5A5A}, KNOWN, '{ST_MISSING, 32'h0, 7'd3}},
      '{'{ACT_INSERT,   16'h0001, 32'h0000_0001}, CALC,  NO_RSP},
      '{'{ACT_INSERT,   16'hFFFE, 32'h8000_0000}, CALC,  NO_RSP},
      '{'{ACT_LOOKUP,   16'h0001, 32'h0000_0000}, CALC,  NO_RSP},
      // Remove at the front and at the back, then drain the rest.
      '{'{ACT_REMOVE,   16'h0000, 32'h0000_0000}, CALC,  NO_RSP},
      '{'{ACT_REMOVE,   16'hFFFF, 32'h0000_0000}, CALC,  NO_RSP},
      '{'{ACT_LOOKUP,   16'hFFFE, 32'h0000_0000}, CALC,  NO_RSP},
      '{'{ACT_REMOVE,   16'h8000, 32'h0000_0000}, CALC,  NO_RSP},
      '{'{ACT_REMOVE,   16'h0001, 32'h0000_0000}, CALC,  NO_RSP},
      '{'{ACT_REMOVE,   16'hFFFE, 32'h0000_0000}, CALC,  NO_RSP},
      '{'{ACT_LOOKUP,   16'hFFFE, 32'h0000_0000}, KNOWN, '{ST_MISSING, 32'h0, 7'd0}}
   };

   // -------------------------------------------------------------------------
   // Stimulus: reset, the directed table, random passes, then the end check.
   // -------------------------------------------------------------------------
   initial begin
      req_type           op;
      traffic_phase_type phase;
      key_span_type      span;
      int                roll;
      int                items_at_full;
      int                mix_left;
      int                empty_extra;
      phase         = PH_FILL;
      span          = SPAN_NARROW;
      items_at_full = 0;
      mix_left      = 0;
      empty_extra   = 0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         send_op(directed_rows[r].op, directed_rows[r].has_known, directed_rows[r].known);
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         roll = $urandom_range(0, 99);
         // Each phase weights the actions differently; a few percent of every
         // phase is the reserved action as noise.
         case (phase)
            PH_FILL: begin
               op.action = (roll < 70) ? ACT_INSERT : (roll < 85) ? ACT_LOOKUP :
                           (roll < 96) ? ACT_REMOVE : ACT_RESERVED;
            end
            PH_MIX: begin
               op.action = (roll < 35) ? ACT_INSERT : (roll < 65) ? ACT_LOOKUP :
                           (roll < 96) ? ACT_REMOVE : ACT_RESERVED;
            end
            default: begin
               op.action = (roll < 10) ? ACT_INSERT : (roll < 30) ? ACT_LOOKUP :
                           (roll < 97) ? ACT_REMOVE : ACT_RESERVED;
            end
         endcase
         op.key    = (op.action == ACT_INSERT) ? random_key(span) : target_key(span);
         op.handle = HANDLE_W'($urandom);
         send_op(op, CALC, NO_RSP);

         // Advance the pass. A fill pass lingers at a full table so that
         // inserts get turned away; a drain pass lingers at an empty one.
         case (phase)
            PH_FILL: begin
               if (mirror_count == CAPACITY) items_at_full++;
               if (items_at_full >= 5) begin
                  phase    = PH_MIX;
                  mix_left = $urandom_range(30, 120);
               end
            end
            PH_MIX: begin
               mix_left--;
               if (mix_left <= 0) phase = PH_DRAIN;
            end
            default: begin
               if (mirror_count == 0) empty_extra++;
               if (empty_extra >= 3) begin
                  phase         = PH_FILL;
                  span          = key_span_type'($urandom_range(0, 2));
                  items_at_full = 0;
                  empty_extra   = 0;
               end
            end
         endcase
      end

      req_valid <= 1'b0;
      // The watchdog bounds the wait for the last response.
      while (answer_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

   // -------------------------------------------------------------------------
   // Receiver and checker. Each accepted response is compared field by field
   // with the oldest prediction. rsp_ready follows a pattern, picked anew at
   // random when the current one runs out, from always ready down to rarely ready.
   // -------------------------------------------------------------------------
   ready_mode_type ready_mode  = RDY_ALWAYS;
   int             mode_cycles = 0;

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (answer_q.size() == 0) begin
            flag_mismatch($sformatf("response with no request pending: status %0d",
                                    rsp_data.status));
         end else begin
            want = answer_q.pop_front();
            if (rsp_data.status !== want.status) begin
               flag_mismatch($sformatf("status %0d, predicted %0d",
                                       rsp_data.status, want.status));
            end
            if (rsp_data.found_handle !== want.found_handle) begin
               flag_mismatch($sformatf("found_handle %h, predicted %h",
                                       rsp_data.found_handle, want.found_handle));
            end
            if (rsp_data.entry_count !== want.entry_count) begin
               flag_mismatch($sformatf("entry_count %0d, predicted %0d",
                                       rsp_data.entry_count, want.entry_count));
            end
         end
      end

      if (mode_cycles == 0) begin
         ready_mode  <= ready_mode_type'($urandom_range(0, 3));
         mode_cycles <= $urandom_range(50, 300);
      end else begin
         mode_cycles <= mode_cycles - 1;
      end
      case (ready_mode)
         RDY_ALWAYS:       rsp_ready <= 1'b1;
         RDY_HALF:         rsp_ready <= $urandom_range(0, 1);
         RDY_EVERY_FOURTH: rsp_ready <= (mode_cycles[1:0] == 2'd0);
         default:          rsp_ready <= ($urandom_range(0, 9) == 0);
      endcase
   end

   // -------------------------------------------------------------------------
   // Watchdog: ends the run when the quiet counter, which a transaction on
   // either channel clears, reaches IDLE_LIMIT.
   // -------------------------------------------------------------------------
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("[%0t] no transaction for %0d cycles", $realtime, IDLE_LIMIT);
         $display("tb failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/skt_pkg.sv
sv/skt_ram.sv
sv/sorted_key_table.sv
tb/sv/tb.sv
